[src/sorted_timer_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted timer queue
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Checks that a condition holds at every clock edge out of reset.
`define STQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define STQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[src/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Constants and types shared by the sorted timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int ID_BITS        = 4;
  localparam int NUM_IDS        = 16;
  localparam int CMD_BITS       = 2;

  localparam logic [CMD_BITS-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_STOP    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_PROCESS = 2'd2;

  // Enables of the slot memory for one cycle.
  typedef struct packed {
    logic we;
    logic re;
  } stq_mem_ctl_t;

endpackage

[src/stq_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_slot_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 36
) (
  input  logic                  clk,
  input  stq_pkg::stq_mem_ctl_t ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [DW-1:0]         wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DW-1:0]         rdata
);
  import stq_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/sorted_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer list kept sorted by fire time in a slot memory, with a sequencer.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: start, stop or process a due head.
// Each request yields one result on out_valid/out_ready carrying the fired
// flag and id, the alarm state of the head and the number of queued timers.
// One request is handled at a time; in_ready is high only while idle.
// Every memory slot visit is a read state followed by a write-back state, so
// stop, start and a process request whose head fires walk the queued slots
// one by one; a start of an id that is already queued first removes it and
// then inserts it anew. The single read port of the slot memory is why each
// visit needs both states.
// The result is held in the output state until out_ready; a stalled receiver
// keeps the block from taking the next request. Reset empties the queue at
// once through the fill count and the per-id queued flags; memory content is
// never read beyond the fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stq_pkg::CMD_BITS-1:0]       in_cmd,
  input  logic [stq_pkg::ID_BITS-1:0]        in_timer_id,
  input  logic [TIME_BITS-1:0]               in_start_time,
  input  logic [TIME_BITS-1:0]               in_expire_delta,
  input  logic [TIME_BITS-1:0]               in_now,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_fired,
  output logic [stq_pkg::ID_BITS-1:0]        out_fired_id,
  output logic                               out_alarm_on,
  output logic [TIME_BITS-1:0]               out_alarm_remaining,
  output logic [$clog2(NUM_TIMERS+1)-1:0]    out_queued_count
);
  import stq_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int DW = TIME_BITS + ID_BITS;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PRD   = 11'b00000000010,
    ST_PWB   = 11'b00000000100,
    ST_DRD   = 11'b00000001000,
    ST_DWB   = 11'b00000010000,
    ST_IRD   = 11'b00000100000,
    ST_IWB   = 11'b00001000000,
    ST_ILAST = 11'b00010000000,
    ST_HRD   = 11'b00100000000,
    ST_HWB   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } stq_state_t;

  stq_state_t           state_r, state_nxt;
  logic [CMD_BITS-1:0]  cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [ID_BITS-1:0]   target_r, target_nxt;
  logic [TIME_BITS-1:0] ft_r, ft_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 found_r, found_nxt;
  logic [DW-1:0]        carry_r, carry_nxt;
  logic                 fired_r, fired_nxt;
  logic [ID_BITS-1:0]   fired_id_r, fired_id_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_IDS-1:0]   id_queued_r, id_queued_nxt;

  stq_mem_ctl_t         mem_ctl;
  logic [IW-1:0]        waddr, raddr;
  logic [DW-1:0]        wdata, rdata;
  logic [TIME_BITS-1:0] d_ft;
  logic [ID_BITS-1:0]   d_id;
  logic [DW-1:0]        new_entry;
  logic                 a_over, b_over, new_first;
  logic                 last_slot;

  stq_slot_mem #(
    .DEPTH(NUM_TIMERS),
    .AW   (IW),
    .DW   (DW)
  ) u_slot_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign d_ft      = rdata[TIME_BITS-1:0];
  assign d_id      = rdata[DW-1:TIME_BITS];
  assign new_entry = {id_r, ft_r};

  // An overdue timer sorts ahead of one that is not; otherwise earlier fire time wins.
  assign a_over    = ft_r < now_r;
  assign b_over    = d_ft < now_r;
  assign new_first = (a_over != b_over) ? a_over : (ft_r < d_ft);
  assign last_slot = (CW'(idx_r + 1'b1) == count_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    target_nxt    = target_r;
    ft_nxt        = ft_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    carry_nxt     = carry_r;
    fired_nxt     = fired_r;
    fired_id_nxt  = fired_id_r;
    rem_nxt       = rem_r;
    id_queued_nxt = id_queued_r;
    mem_ctl       = '0;
    raddr         = idx_r[IW-1:0];
    waddr         = idx_r[IW-1:0];
    wdata         = rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          id_nxt       = in_timer_id;
          target_nxt   = in_timer_id;
          ft_nxt       = in_start_time + in_expire_delta;
          now_nxt      = in_now;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          fired_nxt    = 1'b0;
          fired_id_nxt = '0;
          case (in_cmd)
            CMD_START: begin
              if (id_queued_r[in_timer_id]) begin
                state_nxt = ST_DRD;
              end else if (count_r == CW'(NUM_TIMERS)) begin
                state_nxt = ST_HRD;
              end else if (count_r == '0) begin
                state_nxt = ST_ILAST;
              end else begin
                state_nxt = ST_IRD;
              end
            end
            CMD_STOP: begin
              state_nxt = id_queued_r[in_timer_id] ? ST_DRD : ST_HRD;
            end
            CMD_PROCESS: begin
              state_nxt = (count_r == '0) ? ST_HRD : ST_PRD;
            end
            default: begin
              state_nxt = ST_HRD;
            end
          endcase
        end
      end
      ST_PRD: begin
        mem_ctl.re = 1'b1;
        raddr      = '0;
        state_nxt  = ST_PWB;
      end
      ST_PWB: begin
        if (!(now_r < d_ft)) begin
          fired_nxt    = 1'b1;
          fired_id_nxt = d_id;
          target_nxt   = d_id;
          state_nxt    = ST_DRD;
        end else begin
          state_nxt = ST_HRD;
        end
      end
      ST_DRD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = ST_DWB;
      end
      ST_DWB: begin
        // Entries after the removed one move down by one slot.
        if (found_r) begin
          mem_ctl.we = 1'b1;
          waddr      = idx_r[IW-1:0] - 1'b1;
        end
        if (d_id == target_r) begin
          found_nxt = 1'b1;
        end
        if (last_slot) begin
          count_nxt               = count_r - 1'b1;
          id_queued_nxt[target_r] = 1'b0;
          idx_nxt                 = '0;
          found_nxt               = 1'b0;
          if (cmd_r == CMD_START) begin
            state_nxt = (count_r == CW'(1)) ? ST_ILAST : ST_IRD;
          end else begin
            state_nxt = ST_HRD;
          end
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = ST_DRD;
        end
      end
      ST_IRD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = ST_IWB;
      end
      ST_IWB: begin
        // From the insertion point on, each entry moves up by one slot.
        if (!found_r) begin
          if (new_first) begin
            mem_ctl.we = 1'b1;
            wdata      = new_entry;
            carry_nxt  = rdata;
            found_nxt  = 1'b1;
          end
        end else begin
          mem_ctl.we = 1'b1;
          wdata      = carry_r;
          carry_nxt  = rdata;
        end
        if (last_slot) begin
          state_nxt = ST_ILAST;
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = ST_IRD;
        end
      end
      ST_ILAST: begin
        mem_ctl.we          = 1'b1;
        waddr               = count_r[IW-1:0];
        wdata               = found_r ? carry_r : new_entry;
        count_nxt           = CW'(count_r + 1'b1);
        id_queued_nxt[id_r] = 1'b1;
        state_nxt           = ST_HRD;
      end
      ST_HRD: begin
        if (count_r == '0) begin
          rem_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          mem_ctl.re = 1'b1;
          raddr      = '0;
          state_nxt  = ST_HWB;
        end
      end
      ST_HWB: begin
        rem_nxt   = (now_r < d_ft) ? (d_ft - now_r) : '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      id_queued_r <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      id_queued_r <= id_queued_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    target_r   <= target_nxt;
    ft_r       <= ft_nxt;
    now_r      <= now_nxt;
    carry_r    <= carry_nxt;
    fired_r    <= fired_nxt;
    fired_id_r <= fired_id_nxt;
    rem_r      <= rem_nxt;
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = (state_r == ST_OUT);
  assign out_fired           = fired_r;
  assign out_fired_id        = fired_id_r;
  assign out_alarm_on        = (count_r != '0);
  assign out_alarm_remaining = rem_r;
  assign out_queued_count    = count_r;

`include "sorted_timer_queue_assert.svh"

  `STQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(NUM_TIMERS), "queue count above capacity")
  `STQ_ASSERT_ALWAYS(a_ids_match_count, !in_ready || ($countones(id_queued_r) == 32'(count_r)), "queued id flags disagree with count")
  `STQ_ASSERT_ALWAYS(a_one_at_a_time, !(in_ready && out_valid), "input taken while a result is pending")
  `STQ_ASSERT_NEXT(a_result_leaves, out_valid && out_ready, in_ready, "block not idle after result taken")

endmodule

[verif/sorted_timer_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_tb
// Self-checking bench for the sorted timer queue. A short table of directed
// requests is followed by random start/stop/process traffic. Every result is
// compared with a behavioral copy of the sorted queue kept in the bench.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int NT = 16;
  localparam int N_RANDOM = 530;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [3:0]          id;
    logic [31:0]         st;
    logic [31:0]         dl;
    logic [31:0]         now;
  } timer_req_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_id;
    logic        alarm_on;
    logic [31:0] remaining;
    logic [4:0]  count;
  } alarm_state_t;

  // Directed row: request, whether the result is typed in, and that result.
  typedef struct packed {
    timer_req_t   req;
    logic         known;
    alarm_state_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_BITS-1:0] in_cmd = '0;
  logic [3:0] in_timer_id = '0;
  logic [31:0] in_start_time = '0, in_expire_delta = '0, in_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_fired, out_alarm_on;
  logic [3:0] out_fired_id;
  logic [31:0] out_alarm_remaining;
  logic [4:0] out_queued_count;

  sorted_timer_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_timer_id(in_timer_id), .in_start_time(in_start_time),
    .in_expire_delta(in_expire_delta), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready), .out_fired(out_fired),
    .out_fired_id(out_fired_id), .out_alarm_on(out_alarm_on),
    .out_alarm_remaining(out_alarm_remaining), .out_queued_count(out_queued_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bench copy of the queue.
  logic [31:0] q_fire [NT];
  logic [3:0]  q_id [NT];
  int          q_len;
  alarm_state_t expected_q[$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic bit fires_before(logic [31:0] a, logic [31:0] b, logic [31:0] now);
    bit ao, bo;
    ao = a < now;
    bo = b < now;
    if (ao != bo) return ao;
    return a < b;
  endfunction

  function automatic void remove_at(int pos);
    for (int i = pos; i < q_len - 1; i++) begin
      q_fire[i] = q_fire[i + 1];
      q_id[i] = q_id[i + 1];
    end
    q_len--;
  endfunction

  function automatic void remove_id(logic [3:0] id);
    for (int i = 0; i < q_len; i++) begin
      if (q_id[i] == id) begin
        remove_at(i);
        return;
      end
    end
  endfunction

  function automatic alarm_state_t apply_request(timer_req_t r);
    alarm_state_t s;
    logic [31:0] ft;
    int pos;
    s = '0;
    case (r.cmd)
      CMD_START: begin
        ft = r.st + r.dl;
        remove_id(r.id);
        if (q_len < NT) begin
          pos = q_len;
          for (int i = 0; i < q_len; i++) begin
            if (fires_before(ft, q_fire[i], r.now)) begin
              pos = i;
              break;
            end
          end
          for (int i = q_len; i > pos; i--) begin
            q_fire[i] = q_fire[i - 1];
            q_id[i] = q_id[i - 1];
          end
          q_fire[pos] = ft;
          q_id[pos] = r.id;
          q_len++;
        end
      end
      CMD_STOP: remove_id(r.id);
      CMD_PROCESS: begin
        if (q_len > 0 && r.now >= q_fire[0]) begin
          s.fired = 1'b1;
          s.fired_id = q_id[0];
          remove_at(0);
        end
      end
      default: ;
    endcase
    s.alarm_on = q_len > 0;
    s.count = 5'(q_len);
    if (q_len > 0 && r.now < q_fire[0]) s.remaining = q_fire[0] - r.now;
    return s;
  endfunction

  // Valid drops only when an idle gap follows, so it never gets two updates
  // in one time step.
  task automatic send_request(timer_req_t r);
    int gap;
    gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_timer_id <= r.id;
    in_start_time <= r.st;
    in_expire_delta <= r.dl;
    in_now <= r.now;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic timer_req_t mk(logic [CMD_BITS-1:0] c, logic [3:0] id,
                                    logic [31:0] st, logic [31:0] dl, logic [31:0] now);
    timer_req_t r;
    r.cmd = c; r.id = id; r.st = st; r.dl = dl; r.now = now;
    return r;
  endfunction

  // Result side: random stalls, compare against the oldest expectation.
  initial begin
    alarm_state_t w;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        report_mismatch("result without request", 32'(out_queued_count), 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (out_fired !== w.fired) report_mismatch("fired", 32'(out_fired), 32'(w.fired));
        if (out_fired_id !== w.fired_id)
          report_mismatch("fired_id", 32'(out_fired_id), 32'(w.fired_id));
        if (out_alarm_on !== w.alarm_on)
          report_mismatch("alarm_on", 32'(out_alarm_on), 32'(w.alarm_on));
        if (out_alarm_remaining !== w.remaining)
          report_mismatch("alarm_remaining", out_alarm_remaining, w.remaining);
        if (out_queued_count !== w.count)
          report_mismatch("queued_count", 32'(out_queued_count), 32'(w.count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    timer_req_t r;
    alarm_state_t s;
    logic [31:0] base;
    int burst;
    q_len = 0;
    // Empty queue cases, wrap of the fire time, ties, overdue ordering, unused code.
    rows.push_back('{mk(CMD_PROCESS, 4'd0, 0, 0, 32'hFFFFFFFF), 1'b1, '0});
    rows.push_back('{mk(CMD_STOP, 4'd15, 0, 0, 0), 1'b1, '0});
    rows.push_back('{mk(CMD_UNUSED, 4'd0, 0, 0, 0), 1'b1, '0});
    rows.push_back('{mk(CMD_START, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 0), 1'b1,
                     '{1'b0, 4'd0, 1'b1, 32'hFFFFFFFE, 5'd1}});
    rows.push_back('{mk(CMD_START, 4'd0, 32'hFFFFFFF0, 32'h20, 32'h5), 1'b0, '0});
    rows.push_back('{mk(CMD_START, 4'd1, 32'h10, 32'h0, 32'h5), 1'b0, '0});
    rows.push_back('{mk(CMD_START, 4'd2, 32'h8, 32'h8, 32'h5), 1'b0, '0});
    rows.push_back('{mk(CMD_START, 4'd3, 32'h1, 32'h1, 32'h5), 1'b0, '0});
    rows.push_back('{mk(CMD_START, 4'd1, 32'h100, 32'h0, 32'h5), 1'b0, '0});
    rows.push_back('{mk(CMD_PROCESS, 4'd0, 0, 0, 32'h1), 1'b0, '0});
    rows.push_back('{mk(CMD_PROCESS, 4'd0, 0, 0, 32'h10), 1'b0, '0});
    rows.push_back('{mk(CMD_STOP, 4'd1, 0, 0, 32'h10), 1'b0, '0});
    rows.push_back('{mk(CMD_STOP, 4'd1, 0, 0, 32'h10), 1'b0, '0});
    rows.push_back('{mk(CMD_UNUSED, 4'd9, 32'h1234, 32'h55, 32'h10), 1'b0, '0});
    for (int i = 4; i < 18; i++)
      rows.push_back('{mk(CMD_START, 4'(i), 32'h1000, 32'(i), 32'h20), 1'b0, '0});
    rows.push_back('{mk(CMD_PROCESS, 4'd0, 0, 0, 32'hFFFFFFFF), 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      s = apply_request(rows[k].req);
      if (rows[k].known && s != rows[k].res) begin
        $display("directed row %0d disagrees with the bench queue", k);
        errors++;
      end
      expected_q.push_back(rows[k].known ? rows[k].res : s);
      send_request(rows[k].req);
    end

    // Random traffic: time mostly advances near a moving base, mixed with start,
    // stop, process and unused requests and occasional full-range values.
    base = $urandom();
    for (int n = 0; n < N_RANDOM; n++) begin
      burst = $urandom_range(0, 99);
      base = base + $urandom_range(0, 40);
      r.id = 4'($urandom());
      r.st = base - $urandom_range(0, 20);
      r.dl = $urandom_range(0, 60);
      r.now = base;
      if (burst < 45) r.cmd = CMD_START;
      else if (burst < 60) r.cmd = CMD_STOP;
      else if (burst < 95) r.cmd = CMD_PROCESS;
      else r.cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
        r.st = $urandom();
        r.dl = $urandom();
        r.now = $urandom();
      end
      expected_q.push_back(apply_request(r));
      send_request(r);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
